/* design/ikh_pkg.sv */
package ikh_pkg;

	localparam int BUCKETS   = 256;
	localparam int NODES     = 1024;
	localparam int BKT_W     = $clog2(BUCKETS);
	localparam int NODE_W    = $clog2(NODES);
	localparam int PTR_W     = NODE_W + 1;
	localparam int CNT_W     = NODE_W + 1;
	localparam int BC_W      = 9;
	localparam int KEY_W     = 32;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = KEY_W + 1;
	localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

	localparam logic [2:0] KIND_ADD    = 3'd0;
	localparam logic [2:0] KIND_UPDATE = 3'd1;
	localparam logic [2:0] KIND_NEXT   = 3'd2;
	localparam logic [2:0] KIND_FIND   = 3'd3;
	localparam logic [2:0] KIND_EXISTS = 3'd4;
	localparam logic [2:0] KIND_DELETE = 3'd5;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_UPD,
		OP_NEXT,
		OP_FIND,
		OP_EXISTS,
		OP_DEL,
		OP_BAD
	} op_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] read_value;
		logic [KEY_W-1:0]  key_used;
		logic [CNT_W-1:0]  element_count;
	} out_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} q_item_t;

	typedef struct packed {
		logic start;
		logic done;
	} mod_ctl_t;

endpackage

/* design/ikh_ram.sv */
module ikh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* design/ikh_mod.sv */
module ikh_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ikh_pkg::KEY_W-1:0] dividend,
	input  logic [ikh_pkg::BC_W-1:0]  divisor,
	output logic                      done,
	output logic [ikh_pkg::BKT_W-1:0] result
);
	import ikh_pkg::*;

	// Four restoring steps per cycle; the remainder stays below the divisor.
	logic [KEY_W-1:0] dvd_q;
	logic [BC_W-1:0]  rem_q;
	logic [2:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [BC_W-1:0]  rem_d;

	always_comb begin
		rem_d = rem_q;
		for (int i = 0; i < 4; i++) begin
			rem_d = {rem_d[BC_W-2:0], dvd_q[KEY_W-1-i]};
			if (rem_d >= divisor) begin
				rem_d = rem_d - divisor;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[KEY_W-5:0], 4'd0};
			rem_q <= rem_d;
		end
	end

	assign done   = done_q;
	assign result = rem_q[BKT_W-1:0];
endmodule

/* design/ikh_front.sv */
module ikh_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ikh_pkg::in_t     in_data,
	output logic             q_valid,
	output ikh_pkg::q_item_t q_item,
	input  logic             q_pop
);
	import ikh_pkg::*;

	q_item_t    slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	q_item_t    item_d;
	logic       push;

	always_comb begin
		item_d.key   = in_data.key;
		item_d.value = in_data.value;
		case (in_data.kind)
			KIND_ADD:    item_d.op = OP_ADD;
			KIND_UPDATE: item_d.op = OP_UPD;
			KIND_NEXT:   item_d.op = OP_NEXT;
			KIND_FIND:   item_d.op = OP_FIND;
			KIND_EXISTS: item_d.op = OP_EXISTS;
			KIND_DELETE: item_d.op = OP_DEL;
			default:     item_d.op = OP_BAD;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= item_d;
		end
	end
endmodule

/* design/ikh_back.sv */
module ikh_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [ikh_pkg::BC_W-1:0] cfg_data,
	input  logic                     q_valid,
	input  ikh_pkg::q_item_t         q_item,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output ikh_pkg::out_t            out_data
);
	import ikh_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MOD   = 10'b0000000010,
		S_HEAD  = 10'b0000000100,
		S_HEADW = 10'b0000001000,
		S_NODE  = 10'b0000010000,
		S_CMP   = 10'b0000100000,
		S_POP   = 10'b0001000000,
		S_POPW  = 10'b0010000000,
		S_INS   = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] val_q;
	logic [BKT_W-1:0]  bkt_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  p_q;
	logic [PTR_W-1:0]  prev_q;
	logic [NODE_W-1:0] node_q;
	logic [CNT_W-1:0]  sp_q;
	logic [CNT_W-1:0]  fresh_q;
	logic [CNT_W-1:0]  entry_q;
	logic [IDX_W-1:0]  nidx_q;
	logic [BC_W-1:0]   bc_q;
	logic [BUCKETS-1:0] hvalid_q;
	status_t           res_status_q;
	logic [DATA_W-1:0] res_rv_q;
	logic [KEY_W-1:0]  res_used_q;
	logic              out_valid_q;
	out_t              out_data_q;

	logic [BC_W-1:0]   divisor;
	logic [KEY_W-1:0]  eff_key;
	mod_ctl_t          mod_ctl;
	logic [BKT_W-1:0]  mod_res;

	logic [PTR_W-1:0]  head_rd;
	logic [KEY_W-1:0]  key_rd;
	logic [DATA_W-1:0] val_rd;
	logic [PTR_W-1:0]  next_rd;
	logic [NODE_W-1:0] stk_rd;

	logic              hit;
	logic              is_store;
	logic              pool_empty;
	logic              raise;
	logic              out_free;

	logic              head_we;
	logic [PTR_W-1:0]  head_wd;
	logic              key_we;
	logic              val_we;
	logic [NODE_W-1:0] val_wa;
	logic [DATA_W-1:0] val_wd;
	logic              next_we;
	logic [NODE_W-1:0] next_wa;
	logic [PTR_W-1:0]  next_wd;
	logic              stk_we;

	// Out-of-range counts are clamped; the register keeps what was written.
	always_comb begin
		if (bc_q == '0) begin
			divisor = BC_W'(1);
		end else if (bc_q > BC_W'(BUCKETS)) begin
			divisor = BC_W'(BUCKETS);
		end else begin
			divisor = bc_q;
		end
	end

	assign eff_key    = (q_item.op == OP_NEXT) ? nidx_q[KEY_W-1:0] : q_item.key;
	assign is_store   = (op_q == OP_ADD) || (op_q == OP_UPD) || (op_q == OP_NEXT);
	assign pool_empty = (fresh_q == CNT_W'(NODES)) && (sp_q == '0);
	assign hit        = (state_q == S_CMP) && (key_rd == key_q);
	assign raise      = ({1'b0, key_q} >= nidx_q);
	assign out_free   = !out_valid_q || out_ready;
	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign mod_ctl.start = q_pop && (q_item.op != OP_BAD)
		&& !((q_item.op == OP_NEXT) && nidx_q[IDX_W-1]);

	ikh_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_ctl.start),
		.dividend (eff_key),
		.divisor  (divisor),
		.done     (mod_ctl.done),
		.result   (mod_res)
	);

	always_comb begin
		head_we = 1'b0;
		head_wd = next_rd;
		key_we  = 1'b0;
		val_we  = 1'b0;
		val_wa  = p_q[NODE_W-1:0];
		val_wd  = val_q;
		next_we = 1'b0;
		next_wa = prev_q[NODE_W-1:0];
		next_wd = next_rd;
		stk_we  = 1'b0;
		if (state_q == S_INS) begin
			head_we = 1'b1;
			head_wd = {1'b0, node_q};
			key_we  = 1'b1;
			val_we  = 1'b1;
			val_wa  = node_q;
			next_we = 1'b1;
			next_wa = node_q;
			next_wd = head_q;
		end else if (hit && (op_q == OP_UPD)) begin
			val_we = 1'b1;
		end else if (hit && (op_q == OP_DEL)) begin
			stk_we = 1'b1;
			if (prev_q == NIL) begin
				head_we = 1'b1;
			end else begin
				next_we = 1'b1;
			end
		end
	end

	ikh_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_head (
		.clk(clk), .we(head_we), .waddr(bkt_q), .wdata(head_wd),
		.raddr(bkt_q), .rdata(head_rd)
	);

	ikh_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key (
		.clk(clk), .we(key_we), .waddr(node_q), .wdata(key_q),
		.raddr(p_q[NODE_W-1:0]), .rdata(key_rd)
	);

	ikh_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_val (
		.clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
		.raddr(p_q[NODE_W-1:0]), .rdata(val_rd)
	);

	ikh_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(p_q[NODE_W-1:0]), .rdata(next_rd)
	);

	ikh_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_stack (
		.clk(clk), .we(stk_we), .waddr(sp_q[NODE_W-1:0]), .wdata(p_q[NODE_W-1:0]),
		.raddr(NODE_W'(sp_q - CNT_W'(1))), .rdata(stk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			fresh_q     <= '0;
			entry_q     <= '0;
			nidx_q      <= '0;
			bc_q        <= BC_W'(223);
			hvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				bc_q <= cfg_data;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (mod_ctl.start) begin
							state_q <= S_MOD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MOD: begin
					if (mod_ctl.done) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_HEADW;
				end
				S_HEADW: begin
					state_q <= S_NODE;
				end
				S_NODE: begin
					if (p_q != NIL) begin
						state_q <= S_CMP;
					end else if (is_store && !pool_empty) begin
						if (sp_q != '0) begin
							state_q <= S_POP;
						end else begin
							fresh_q <= fresh_q + CNT_W'(1);
							state_q <= S_INS;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_CMP: begin
					if (hit) begin
						if (op_q == OP_UPD && raise) begin
							nidx_q <= {1'b0, key_q} + IDX_W'(1);
						end
						if (op_q == OP_DEL) begin
							hvalid_q[bkt_q] <= 1'b1;
							sp_q            <= sp_q + CNT_W'(1);
							if (entry_q != '0) begin
								entry_q <= entry_q - CNT_W'(1);
							end
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_NODE;
					end
				end
				S_POP: begin
					state_q <= S_POPW;
				end
				S_POPW: begin
					sp_q    <= sp_q - CNT_W'(1);
					state_q <= S_INS;
				end
				S_INS: begin
					hvalid_q[bkt_q] <= 1'b1;
					entry_q         <= entry_q + CNT_W'(1);
					if (raise) begin
						nidx_q <= {1'b0, key_q} + IDX_W'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q         <= q_item.op;
				val_q        <= q_item.value;
				key_q        <= eff_key;
				res_rv_q     <= '0;
				res_status_q <= ST_MISS;
				res_used_q   <= q_item.key;
				if (q_item.op == OP_NEXT) begin
					if (nidx_q[IDX_W-1]) begin
						res_status_q <= ST_FULL;
						res_used_q   <= '0;
					end else begin
						res_used_q <= eff_key;
					end
				end
			end
			S_MOD: begin
				bkt_q <= mod_res;
			end
			S_HEADW: begin
				head_q <= hvalid_q[bkt_q] ? head_rd : NIL;
				p_q    <= hvalid_q[bkt_q] ? head_rd : NIL;
				prev_q <= NIL;
			end
			S_NODE: begin
				node_q <= fresh_q[NODE_W-1:0];
				if ((p_q == NIL) && is_store && pool_empty) begin
					res_status_q <= ST_FULL;
				end
			end
			S_CMP: begin
				if (hit) begin
					case (op_q)
						OP_UPD: begin
							res_status_q <= ST_OK;
							res_rv_q     <= val_q;
						end
						OP_FIND: begin
							res_status_q <= ST_OK;
							res_rv_q     <= val_rd;
						end
						OP_EXISTS, OP_DEL: begin
							res_status_q <= ST_OK;
						end
						default: begin
							res_status_q <= ST_MISS;
						end
					endcase
				end else begin
					prev_q <= p_q;
					p_q    <= next_rd;
				end
			end
			S_POPW: begin
				node_q <= stk_rd;
			end
			S_INS: begin
				res_status_q <= ST_OK;
				res_rv_q     <= val_q;
			end
			S_DONE: begin
				if (out_free) begin
					out_data_q.status        <= res_status_q;
					out_data_q.read_value    <= res_rv_q;
					out_data_q.key_used      <= res_used_q;
					out_data_q.element_count <= entry_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
endmodule

/* design/integer_key_chained_hash_map.sv */
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_ready  in_data   (ikh_pkg::in_t: kind, key, value)
// out       output     out_valid/out_ready  out_data  (ikh_pkg::out_t: status, read_value,
//                                                       key_used, element_count)
// cfg       input      cfg_we               cfg_data  (bucket count, 9 bits)
//
// A lookup that hits takes the transaction from the queue, reduces the key modulo the
// bucket count in the four-bit-per-cycle remainder unit, reads the bucket head, walks the
// chain through node memory one node at a time and presents the result. A store that
// reaches the end of the chain with a free node links it at the head of the chain, popping
// it from the free stack when that holds one. Unknown kinds and an exhausted index go
// straight to the result. Operations are carried out one at a time, and a stalled result
// holds the back end until it is taken.
// Reset clears the bucket valid bits, the free pool and all counters at once; no sweep.
// A two-entry queue takes input transactions while the back end works or a result stalls.
module integer_key_chained_hash_map (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  ikh_pkg::in_t             in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output ikh_pkg::out_t            out_data,
	input  logic                     cfg_we,
	input  logic [ikh_pkg::BC_W-1:0] cfg_data
);
	import ikh_pkg::*;

	// Decoded operations waiting for the back end.
	logic    q_valid;
	q_item_t q_item;
	logic    q_pop;

	// The front end decodes the kind and buffers the transaction.
	ikh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// The back end hashes the key, walks the chain and updates the tables, then holds the
	// result in its output register until it is taken.
	ikh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);
endmodule

/* design/ikh_checker.sv */
module ikh_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input ikh_pkg::out_t out_data
);
	import ikh_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status != 2'd3) && (out_data.element_count <= CNT_W'(NODES)))
		else $error("bad status or element count");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != ST_OK) |-> (out_data.read_value == '0))
		else $error("failed operation returned data");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_FULL) && (out_data.key_used != '0)
		|-> (out_data.element_count == CNT_W'(NODES)))
		else $error("pool full reported with free nodes");
endmodule

bind integer_key_chained_hash_map ikh_checker u_ikh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the chained hash map. A predictor inside the bench
// keeps its own bucket heads, node memory, free stack and counters. It works out
// the result of every input transaction at the clock edge where that transaction
// is accepted. A checker process compares each output transaction, field by
// field, with the oldest expected result.
module tb;
	import ikh_pkg::*;

	// Kinds that the block must ignore.
	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 40;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	in_t           in_data;
	logic          out_valid;
	logic          out_ready;
	out_t          out_data;
	logic          cfg_we;
	logic [BC_W-1:0] cfg_data;

	integer_key_chained_hash_map dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Predicted copy of the map state.
	logic [PTR_W-1:0]  pm_head [BUCKETS];
	logic [KEY_W-1:0]  pm_key  [NODES];
	logic [DATA_W-1:0] pm_val  [NODES];
	logic [PTR_W-1:0]  pm_next [NODES];
	logic [NODE_W-1:0] pm_free [NODES];
	int                pm_free_cnt;
	int                pm_total;
	logic [IDX_W-1:0]  pm_next_idx;
	logic [BC_W-1:0]   pm_bcount;

	out_t pending_results [$];
	int   error_count;
	int   cycle_count;
	bit   quiet_mode;   // when set, neither side idles

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch in %s: got %0h, expected %0h", what, got, want);
		error_count++;
	endtask

	function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] k);
		int n;
		n = pm_bcount;
		if (n == 0) n = 1;
		if (n > BUCKETS) n = BUCKETS;
		return BKT_W'(k % n);
	endfunction

	// Walks a chain; returns the node holding k or NIL, and its predecessor.
	function automatic logic [PTR_W-1:0] walk_chain(input logic [BKT_W-1:0] b,
			input logic [KEY_W-1:0] k, output logic [PTR_W-1:0] prev);
		logic [PTR_W-1:0] p;
		int steps;
		p = pm_head[b];
		prev = NIL;
		steps = 0;
		while (p < NODES && steps < NODES) begin
			if (pm_key[p] == k) break;
			prev = p;
			p = pm_next[p];
			steps++;
		end
		if (p >= NODES || steps >= NODES) p = NIL;
		return p;
	endfunction

	function automatic void raise_index(input logic [KEY_W-1:0] k);
		if ({1'b0, k} >= pm_next_idx) pm_next_idx = {1'b0, k} + 1'b1;
	endfunction

	// Applies one operation to the predicted state and returns its result.
	function automatic out_t apply_operation(input in_t t);
		out_t r;
		logic [KEY_W-1:0] k;
		logic [BKT_W-1:0] b;
		logic [PTR_W-1:0] p, prev;
		logic ok;
		k = t.key;
		r.status = ST_MISS;
		r.read_value = '0;
		r.key_used = t.key;
		ok = 1'b1;
		if (t.kind <= KIND_NEXT) begin
			if (t.kind == KIND_NEXT) begin
				if (pm_next_idx[KEY_W]) begin
					r.status = ST_FULL;
					r.key_used = '0;
					ok = 1'b0;
				end else begin
					k = pm_next_idx[KEY_W-1:0];
					r.key_used = k;
				end
			end
			if (ok) begin
				b = bucket_of(k);
				p = walk_chain(b, k, prev);
				if (p != NIL) begin
					if (t.kind == KIND_UPDATE) begin
						pm_val[p] = t.value;
						raise_index(k);
						r.status = ST_OK;
						r.read_value = t.value;
					end
				end else if (pm_free_cnt == 0) begin
					r.status = ST_FULL;
				end else begin
					pm_free_cnt--;
					p = {1'b0, pm_free[pm_free_cnt]};
					pm_key[p] = k;
					pm_val[p] = t.value;
					pm_next[p] = pm_head[b];
					pm_head[b] = p;
					pm_total++;
					raise_index(k);
					r.status = ST_OK;
					r.read_value = t.value;
				end
			end
		end else if (t.kind == KIND_FIND || t.kind == KIND_EXISTS) begin
			p = walk_chain(bucket_of(k), k, prev);
			if (p != NIL) begin
				r.status = ST_OK;
				if (t.kind == KIND_FIND) r.read_value = pm_val[p];
			end
		end else if (t.kind == KIND_DELETE) begin
			b = bucket_of(k);
			p = walk_chain(b, k, prev);
			if (p != NIL) begin
				if (prev == NIL) pm_head[b] = pm_next[p];
				else pm_next[prev] = pm_next[p];
				if (pm_free_cnt < NODES) begin
					pm_free[pm_free_cnt] = p[NODE_W-1:0];
					pm_free_cnt++;
				end
				if (pm_total > 0) pm_total--;
				r.status = ST_OK;
			end
		end
		r.element_count = CNT_W'(pm_total);
		return r;
	endfunction

	function automatic int draw_gap();
		return quiet_mode ? 0 : $urandom_range(16, 0);
	endfunction

	// Sends one transaction; called and returning at a rising edge. Valid is left
	// high so that back-to-back items never drop it within one time step.
	task automatic send_op(input logic [2:0] kind, input logic [KEY_W-1:0] key,
			input logic [DATA_W-1:0] value);
		int gap;
		in_t t;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		t.kind = kind;
		t.key = key;
		t.value = value;
		in_valid <= 1'b1;
		in_data <= t;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		pending_results.push_back(apply_operation(t));
	endtask

	// Drops valid and waits until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_bucket_count(input logic [BC_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pm_bcount = v;
	endtask

	// Receiver: stalls a random number of cycles before each result.
	int stall_left;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(out_data.key_used), 64'd0);
			end else begin
				out_t want;
				want = pending_results.pop_front();
				if (out_data.status !== want.status)
					report_mismatch("status", 64'(out_data.status), 64'(want.status));
				if (out_data.read_value !== want.read_value)
					report_mismatch("read_value", 64'(out_data.read_value),
						64'(want.read_value));
				if (out_data.key_used !== want.key_used)
					report_mismatch("key_used", 64'(out_data.key_used),
						64'(want.key_used));
				if (out_data.element_count !== want.element_count)
					report_mismatch("element_count", 64'(out_data.element_count),
						64'(want.element_count));
			end
			stall_left = draw_gap();
			out_ready <= (stall_left == 0);
		end else if (stall_left != 0) begin
			stall_left = stall_left - 1;
			out_ready <= (stall_left == 0);
		end
	end

	// Every operation on fresh state, collisions within a chain and unknown kinds.
	task automatic test_directed();
		send_op(KIND_FIND, 32'd5, 32'hFFFF_FFFF);
		send_op(KIND_ADD, 32'd5, 32'hA5A5_0001);
		send_op(KIND_ADD, 32'd5, 32'h1111_1111);
		send_op(KIND_UPDATE, 32'd5, 32'hFFFF_FFFF);
		send_op(KIND_UPDATE, 32'd7, 32'h0000_0000);
		send_op(KIND_ADD, 32'd228, 32'h0000_0228);
		send_op(KIND_ADD, 32'd451, 32'h0000_0451);
		send_op(KIND_FIND, 32'd5, 32'd0);
		send_op(KIND_FIND, 32'd228, 32'd0);
		send_op(KIND_FIND, 32'd9, 32'd0);
		send_op(KIND_EXISTS, 32'd451, 32'hDEAD_BEEF);
		send_op(KIND_EXISTS, 32'd674, 32'd0);
		send_op(KIND_DELETE, 32'd228, 32'd0);
		send_op(KIND_FIND, 32'd451, 32'd0);
		send_op(KIND_DELETE, 32'd228, 32'd0);
		send_op(KIND_NEXT, 32'hFFFF_FFFF, 32'h7777_7777);
		send_op(KIND_NEXT, 32'd0, 32'h8888_8888);
		send_op(KIND_ADD, 32'd0, 32'd0);
		send_op(KIND_NEXT, 32'd0, 32'd1);
		send_op(KIND_SPARE6, 32'd5, 32'hFFFF_FFFF);
		send_op(KIND_SPARE7, 32'hFFFF_FFFF, 32'd3);
		send_op(KIND_DELETE, 32'd5, 32'd0);
		send_op(KIND_DELETE, 32'd451, 32'd0);
	endtask

	// Out-of-range and extreme bucket counts; stored entries are not rehashed.
	task automatic test_bucket_counts();
		write_bucket_count(9'd0);
		send_op(KIND_ADD, 32'd1000, 32'h1);
		send_op(KIND_ADD, 32'd2001, 32'h2);
		send_op(KIND_FIND, 32'd1000, 32'd0);
		write_bucket_count(9'd256);
		send_op(KIND_FIND, 32'd1000, 32'd0);
		send_op(KIND_FIND, 32'd2001, 32'd0);
		send_op(KIND_ADD, 32'd1000, 32'h3);
		write_bucket_count(9'd511);
		send_op(KIND_FIND, 32'd1000, 32'd0);
		send_op(KIND_DELETE, 32'd1000, 32'd0);
		write_bucket_count(9'd1);
		send_op(KIND_FIND, 32'd1000, 32'd0);
		send_op(KIND_DELETE, 32'd2001, 32'd0);
		send_op(KIND_DELETE, 32'd1000, 32'd0);
		send_op(KIND_ADD, 32'd3, 32'h4);
		send_op(KIND_DELETE, 32'd3, 32'd0);
	endtask

	function automatic logic [KEY_W-1:0] draw_key();
		int sel;
		sel = $urandom_range(9, 0);
		if (sel < 6) return KEY_W'($urandom_range(63, 0));
		if (sel < 8) return KEY_W'($urandom_range(2000, 0));
		return $urandom();
	endfunction

	// Random operations with keys weighted towards small values, in phases with different counts.
	task automatic test_random();
		logic [2:0] kind;
		int sel;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_bucket_count(9'd223);
				1: write_bucket_count(9'd1);
				2: write_bucket_count(9'd256);
				3: write_bucket_count(BC_W'($urandom_range(511, 0)));
				4: write_bucket_count(BC_W'($urandom_range(16, 2)));
				default: write_bucket_count(9'd223);
			endcase
			quiet_mode = (phase == 2);
			for (int i = 0; i < 125; i++) begin
				sel = $urandom_range(99, 0);
				if (sel < 25) kind = KIND_ADD;
				else if (sel < 40) kind = KIND_UPDATE;
				else if (sel < 47) kind = KIND_NEXT;
				else if (sel < 67) kind = KIND_FIND;
				else if (sel < 77) kind = KIND_EXISTS;
				else if (sel < 97) kind = KIND_DELETE;
				else kind = 3'($urandom_range(7, 6));
				send_op(kind, draw_key(), $urandom());
				// The sender once holds off until the block has fully drained.
				if (phase == 3 && i == 60) drain();
			end
		end
		quiet_mode = 1'b0;
	endtask

	// The largest key exhausts the index; next insert then reports it.
	task automatic test_index_exhausted();
		send_op(KIND_ADD, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
		send_op(KIND_NEXT, 32'd12, 32'h1234_5678);
		send_op(KIND_FIND, 32'hFFFF_FFFF, 32'd0);
		send_op(KIND_UPDATE, 32'hFFFF_FFFE, 32'h9);
		send_op(KIND_NEXT, 32'd0, 32'd0);
	endtask

	// Fills the node pool and checks that further insertions are refused.
	task automatic test_pool_full();
		int i;
		write_bucket_count(9'd256);
		quiet_mode = 1'b1;
		i = 0;
		while (pm_free_cnt > 0) begin
			send_op(KIND_ADD, 32'h4000_0000 + i, $urandom());
			i++;
		end
		quiet_mode = 1'b0;
		send_op(KIND_ADD, 32'h0000_0011, 32'h1);
		send_op(KIND_UPDATE, 32'h7FFF_0000, 32'h2);
		send_op(KIND_UPDATE, 32'h4000_0003, 32'h3);
		send_op(KIND_DELETE, 32'h4000_0007, 32'd0);
		send_op(KIND_ADD, 32'h0000_0011, 32'h4);
		send_op(KIND_FIND, 32'h0000_0011, 32'd0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b1;
		cfg_we = 1'b0;
		cfg_data = '0;
		stall_left = 0;
		error_count = 0;
		cycle_count = 0;
		quiet_mode = 1'b0;
		for (int b = 0; b < BUCKETS; b++) pm_head[b] = NIL;
		for (int n = 0; n < NODES; n++) pm_free[n] = NODE_W'(n);
		pm_free_cnt = NODES;
		pm_total = 0;
		pm_next_idx = '0;
		pm_bcount = 9'd223;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_bucket_counts();
		test_random();
		test_index_exhausted();
		test_pool_full();

		drain();
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/ikh_pkg.sv
design/ikh_ram.sv
design/ikh_mod.sv
design/ikh_front.sv
design/ikh_back.sv
design/integer_key_chained_hash_map.sv
design/ikh_checker.sv
tb/tb.sv
